[src/linked_list_queue_manager_unit_macros.svh]
// Assertion helpers for the queue manager checks
`ifndef LINKED_LIST_QUEUE_MANAGER_UNIT_MACROS_SVH
`define LINKED_LIST_QUEUE_MANAGER_UNIT_MACROS_SVH

// check outside reset
`define LLQM_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("llqm check failed");

// check at every edge, reset included
`define LLQM_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("llqm check failed");

`endif

[src/llqm_pkg.sv]
`default_nettype none
package llqm_pkg;

  localparam int CMD_W        = 2;
  localparam int QUEUE_ID_W   = 3;
  localparam int ENTRY_ID_W   = 6;
  localparam int STATUS_W     = 2;

  localparam int DEF_NUM_ENTRIES = 64;
  localparam int DEF_NUM_QUEUES  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                  command;
    logic [QUEUE_ID_W-1:0] queue_id;
    logic [ENTRY_ID_W-1:0] entry_id;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [ENTRY_ID_W-1:0] entry_out;
    logic                  entry_valid;
    logic                  queue_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DEQ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_in;
    logic do_eval;
    logic do_deq;
    logic in_emit;
    logic do_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic deq_go;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[src/llqm_ram.sv]
`default_nettype none
module llqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[src/llqm_ctrl.sv]
`default_nettype none
module llqm_ctrl
  import llqm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_in = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.do_eval = 1'b1;
        state_nxt   = stat.deq_go ? S_DEQ : S_EMIT;
      end
      S_DEQ: begin
        cmd.do_deq = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.in_emit = 1'b1;
        if (stat.out_free) begin
          cmd.do_emit = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

[src/llqm_dp.sv]
`default_nettype none
module llqm_dp
  import llqm_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int NUM_QUEUES  = DEF_NUM_QUEUES
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_data,
  input  wire ctrl_cmd_t cmd,
  output dp_stat_t       stat
);

  localparam int LW = $clog2(NUM_ENTRIES + 1);
  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_ENTRIES);

  cmd_t            cmd_r;
  logic [QW-1:0]   q_r;
  logic [EW-1:0]   ent_r;
  logic            q_ok_r;
  logic            e_ok_r;
  logic            push_link_r;
  logic [EW-1:0]   link_addr_r;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r;
  logic [NUM_ENTRIES-1:0] linked_r;
  logic [NUM_QUEUES-1:0]  qvalid_r;

  logic [2*LW-1:0] ht_rd, ht_wdata;
  logic [LW-1:0]   next_rd, prev_rd;
  logic [QW-1:0]   owner_rd;
  logic [LW-1:0]   head, tail, nx, pv, new_head, new_tail;
  logic            head_nil, push_ok, rem_ok, unlink, deq_go, ht_we;
  logic [EW-1:0]   ent_raddr;
  logic [QW-1:0]   q_raddr;
  logic            next_we, prev_we, owner_we;
  logic [EW-1:0]   next_waddr, prev_waddr;
  logic [LW-1:0]   next_wdata, prev_wdata;

  assign head     = qvalid_r[q_r] ? ht_rd[2*LW-1:LW] : NIL;
  assign tail     = qvalid_r[q_r] ? ht_rd[LW-1:0] : NIL;
  assign nx       = next_rd;
  assign pv       = prev_rd;
  assign head_nil = (head == NIL);
  assign new_head = (pv != NIL) ? head : nx;
  assign new_tail = (nx != NIL) ? tail : pv;

  assign push_ok = q_ok_r && (cmd_r == CMD_PUSH) && e_ok_r && !linked_r[ent_r];
  assign rem_ok  = q_ok_r && (cmd_r == CMD_REMOVE) && e_ok_r && linked_r[ent_r]
                   && (owner_rd == q_r);
  assign deq_go  = cmd.do_eval && q_ok_r && (cmd_r == CMD_DEQUEUE) && !head_nil;
  assign unlink  = (cmd.do_eval && rem_ok) || cmd.do_deq;

  assign ent_raddr = cmd.load_in ? EW'(in_data.entry_id) : (deq_go ? EW'(head) : ent_r);
  assign q_raddr   = cmd.load_in ? QW'(in_data.queue_id) : q_r;

  always_comb begin
    res_nxt.status      = ST_ERROR;
    res_nxt.entry_out   = '0;
    res_nxt.entry_valid = 1'b0;
    res_nxt.queue_empty = head_nil;
    if (cmd.do_deq) begin
      res_nxt.status      = ST_OK;
      res_nxt.entry_out   = ENTRY_ID_W'(ent_r);
      res_nxt.entry_valid = 1'b1;
      res_nxt.queue_empty = (new_head == NIL);
    end else if (!q_ok_r) begin
      res_nxt.queue_empty = 1'b1;
    end else begin
      case (cmd_r)
        CMD_PUSH: begin
          if (push_ok) begin
            res_nxt.status      = ST_OK;
            res_nxt.queue_empty = 1'b0;
          end
        end
        CMD_REMOVE: begin
          if (rem_ok) begin
            res_nxt.status      = ST_OK;
            res_nxt.entry_out   = (nx != NIL) ? ENTRY_ID_W'(nx) : '0;
            res_nxt.entry_valid = (nx != NIL);
            res_nxt.queue_empty = (new_head == NIL);
          end
        end
        CMD_DEQUEUE: begin
          if (head_nil) begin
            res_nxt.status      = ST_EMPTY;
            res_nxt.queue_empty = 1'b1;
          end
        end
        CMD_QUERY: begin
          res_nxt.status = ST_OK;
        end
        default: begin
          res_nxt.status = ST_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = ent_r;
    next_wdata = NIL;
    prev_we    = 1'b0;
    prev_waddr = ent_r;
    prev_wdata = tail;
    owner_we   = cmd.do_eval && push_ok;
    ht_we      = 1'b0;
    ht_wdata   = {new_head, new_tail};
    if (cmd.in_emit) begin
      next_we    = push_link_r;
      next_waddr = link_addr_r;
      next_wdata = LW'(ent_r);
    end else if (cmd.do_eval && push_ok) begin
      next_we  = 1'b1;
      prev_we  = 1'b1;
      ht_we    = 1'b1;
      ht_wdata = {((tail == NIL) ? LW'(ent_r) : head), LW'(ent_r)};
    end else if (unlink) begin
      next_we    = (pv != NIL);
      next_waddr = EW'(pv);
      next_wdata = nx;
      prev_we    = (nx != NIL);
      prev_waddr = EW'(nx);
      prev_wdata = pv;
      ht_we      = 1'b1;
    end
  end

  llqm_ram #(.WIDTH(LW), .DEPTH(NUM_ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (ent_raddr),
    .rdata (next_rd)
  );

  llqm_ram #(.WIDTH(LW), .DEPTH(NUM_ENTRIES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (ent_raddr),
    .rdata (prev_rd)
  );

  llqm_ram #(.WIDTH(QW), .DEPTH(NUM_ENTRIES)) u_owner_ram (
    .clk   (clk),
    .we    (owner_we),
    .waddr (ent_r),
    .wdata (q_r),
    .raddr (ent_raddr),
    .rdata (owner_rd)
  );

  llqm_ram #(.WIDTH(2*LW), .DEPTH(NUM_QUEUES)) u_ht_ram (
    .clk   (clk),
    .we    (ht_we),
    .waddr (q_r),
    .wdata (ht_wdata),
    .raddr (q_raddr),
    .rdata (ht_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_data.command;
      q_r    <= QW'(in_data.queue_id);
      ent_r  <= EW'(in_data.entry_id);
      q_ok_r <= (32'(in_data.queue_id) < NUM_QUEUES);
      e_ok_r <= (32'(in_data.entry_id) < NUM_ENTRIES);
    end else if (deq_go) begin
      ent_r <= EW'(head);
    end
    if (cmd.do_eval || cmd.do_deq) begin
      res_r <= res_nxt;
    end
    if (cmd.do_eval) begin
      link_addr_r <= EW'(tail);
    end
    if (cmd.do_emit) begin
      out_data_r <= res_r;
    end
  end

  always_comb begin
    if (cmd.do_emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      push_link_r <= 1'b0;
      linked_r    <= '0;
      qvalid_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.do_eval) begin
        push_link_r <= push_ok && (tail != NIL);
      end
      if (cmd.do_eval && push_ok) begin
        linked_r[ent_r] <= 1'b1;
      end else if (unlink) begin
        linked_r[ent_r] <= 1'b0;
      end
      if (ht_we) begin
        qvalid_r[q_r] <= 1'b1;
      end
    end
  end

  assign stat.deq_go   = deq_go;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule
`default_nettype wire

[src/linked_list_queue_manager_unit.sv]
// Queue manager: NUM_QUEUES FIFO queues kept as doubly linked lists over a
// pool of NUM_ENTRIES slots. Each request on the in_ channel (valid/stall)
// carries a command, a queue and an entry; each gives exactly one result
// on the out_ channel (valid/stall) with status, entry, entry valid flag
// and the queue's emptiness after the command.
// One request is in flight at a time. in_stall stays high from acceptance
// until the result moves into the output register. Push, remove, query and
// errors go from acceptance through S_EVAL to S_EMIT and out_valid; a
// dequeue of a non-empty queue also passes through S_DEQ, since the head's
// links are read from the link memories after the head itself comes out of
// the head/tail memory.
// While out_stall holds a result, the next request is still accepted and
// processed; its result waits until the output register frees up.
// Synchronous reset empties all queues and clears out_valid; the block
// accepts requests from the first cycle after reset.
`default_nettype none
module linked_list_queue_manager_unit
  import llqm_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int NUM_QUEUES  = DEF_NUM_QUEUES
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  llqm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  llqm_dp #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .NUM_QUEUES  (NUM_QUEUES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

[src/llqm_checker.sv]
`default_nettype none
`include "linked_list_queue_manager_unit_macros.svh"
module llqm_checker
  import llqm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  `LLQM_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  `LLQM_ASSERT(a_one_in_flight, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
  `LLQM_ASSERT(a_out_hold, clk, rst_n,
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
  `LLQM_ASSERT(a_entry_zero, clk, rst_n,
    (out_valid && !out_data.entry_valid) |-> (out_data.entry_out == '0))
  `LLQM_ASSERT(a_empty_status, clk, rst_n,
    (out_valid && out_data.status == ST_EMPTY) |->
    (out_data.queue_empty && !out_data.entry_valid))

endmodule

bind linked_list_queue_manager_unit llqm_checker u_llqm_checker (.*);
`default_nettype wire

[verif/linked_list_queue_manager_unit_test.sv]
`timescale 1ns / 1ps
module linked_list_queue_manager_unit_test;
  import llqm_pkg::*;

  localparam int POOL = DEF_NUM_ENTRIES;
  localparam int QUEUES = DEF_NUM_QUEUES;
  localparam logic [6:0] NIL = 7'(DEF_NUM_ENTRIES);
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  linked_list_queue_manager_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  logic [6:0] link_next [POOL];
  logic [6:0] link_prev [POOL];
  logic [2:0] slot_owner [POOL];
  logic slot_busy [POOL];
  logic [6:0] q_head [QUEUES];
  logic [6:0] q_tail [QUEUES];

  out_item_t pending_results[$];
  int errors = 0;
  int idle_count = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;
  int stall_mode = 0;
  int stall_run = 0;
  int stall_phase = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void unlink_slot(int q, int e);
    logic [6:0] nx;
    logic [6:0] pv;
    nx = link_next[e];
    pv = link_prev[e];
    if (pv != NIL) link_next[pv] = nx;
    else q_head[q] = nx;
    if (nx != NIL) link_prev[nx] = pv;
    else q_tail[q] = pv;
    link_next[e] = NIL;
    link_prev[e] = NIL;
    slot_busy[e] = 1'b0;
  endfunction

  function automatic out_item_t apply_queue_cmd(in_item_t req);
    out_item_t res;
    logic [6:0] h;
    logic [6:0] nx;
    int q;
    int e;
    q = req.queue_id;
    e = req.entry_id;
    res = '0;
    res.status = ST_OK;
    case (req.command)
      CMD_PUSH: begin
        if (slot_busy[e]) begin
          res.status = ST_ERROR;
        end else begin
          link_next[e] = NIL;
          link_prev[e] = q_tail[q];
          if (q_tail[q] != NIL) link_next[q_tail[q]] = 7'(e);
          else q_head[q] = 7'(e);
          q_tail[q] = 7'(e);
          slot_owner[e] = 3'(q);
          slot_busy[e] = 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        if (q_head[q] == NIL) begin
          res.status = ST_EMPTY;
        end else begin
          h = q_head[q];
          unlink_slot(q, h);
          res.entry_out = h[5:0];
          res.entry_valid = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!slot_busy[e] || slot_owner[e] != 3'(q)) begin
          res.status = ST_ERROR;
        end else begin
          nx = link_next[e];
          unlink_slot(q, e);
          if (nx != NIL) begin
            res.entry_out = nx[5:0];
            res.entry_valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.queue_empty = (q_head[q] == NIL);
    return res;
  endfunction

  function automatic in_item_t pick_request();
    in_item_t req;
    int roll;
    int start;
    int k;
    int idx;
    bit found;
    req.command = cmd_t'($urandom_range(0, 3));
    req.queue_id = 3'($urandom_range(0, QUEUES - 1));
    req.entry_id = 6'($urandom_range(0, POOL - 1));
    roll = $urandom_range(0, 99);
    start = $urandom_range(0, POOL - 1);
    found = 1'b0;
    if (roll < 34) begin
      for (k = 0; k < POOL && !found; k++) begin
        idx = (start + k) % POOL;
        if (!slot_busy[idx]) begin
          found = 1'b1;
          req.command = CMD_PUSH;
          req.entry_id = idx[5:0];
        end
      end
    end else if (roll < 58) begin
      for (k = 0; k < QUEUES && !found; k++) begin
        idx = (start + k) % QUEUES;
        if (q_head[idx] != NIL) begin
          found = 1'b1;
          req.command = CMD_DEQUEUE;
          req.queue_id = idx[2:0];
        end
      end
    end else if (roll < 82) begin
      for (k = 0; k < POOL && !found; k++) begin
        idx = (start + k) % POOL;
        if (slot_busy[idx]) begin
          found = 1'b1;
          req.command = CMD_REMOVE;
          req.entry_id = idx[5:0];
          req.queue_id = slot_owner[idx];
        end
      end
    end else if (roll < 87) begin
      req.command = CMD_QUERY;
    end
    return req;
  endfunction

  // present one request and hold it until accepted
  task automatic send_request(in_item_t req, bit bursty);
    int gap;
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_queue_cmd(req));
    if (bursty) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : $urandom_range(1, 5);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_cmd(cmd_t c, int q, int e);
    in_item_t req;
    req.command = c;
    req.queue_id = 3'(q);
    req.entry_id = 6'(e);
    send_request(req, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(CMD_DEQUEUE, 0, 63);
    send_cmd(CMD_QUERY, 7, 0);
    send_cmd(CMD_PUSH, 0, 0);
    send_cmd(CMD_PUSH, 0, 63);
    send_cmd(CMD_PUSH, 7, 0);
    send_cmd(CMD_REMOVE, 7, 63);
    send_cmd(CMD_PUSH, 0, 21);
    send_cmd(CMD_PUSH, 7, 42);
    send_cmd(CMD_QUERY, 0, 63);
    send_cmd(CMD_REMOVE, 0, 63);
    send_cmd(CMD_REMOVE, 0, 21);
    send_cmd(CMD_DEQUEUE, 0, 0);
    send_cmd(CMD_DEQUEUE, 7, 0);
    send_cmd(CMD_REMOVE, 7, 42);
    send_cmd(CMD_QUERY, 3, 0);
    send_cmd(CMD_PUSH, 3, 5);
    send_cmd(CMD_PUSH, 3, 6);
    send_cmd(CMD_PUSH, 3, 7);
    send_cmd(CMD_REMOVE, 3, 5);
    send_cmd(CMD_REMOVE, 3, 6);
    send_cmd(CMD_DEQUEUE, 3, 0);
    send_cmd(CMD_DEQUEUE, 3, 0);
    wait_drained();
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_request(pick_request(), 1'b1);
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (60) send_request(pick_request(), 1'b0);
    wait_drained();
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (stall_run == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_run = $urandom_range(10, 80);
        end
        stall_run--;
        stall_phase++;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((stall_phase % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t status: expected %0d actual %0d", $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.entry_out !== want.entry_out) begin
          $display("%0t entry_out: expected %0d actual %0d", $time, want.entry_out,
                   out_data.entry_out);
          errors++;
        end
        if (out_data.entry_valid !== want.entry_valid) begin
          $display("%0t entry_valid: expected %0d actual %0d", $time, want.entry_valid,
                   out_data.entry_valid);
          errors++;
        end
        if (out_data.queue_empty !== want.queue_empty) begin
          $display("%0t queue_empty: expected %0d actual %0d", $time, want.queue_empty,
                   out_data.queue_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    for (int i = 0; i < POOL; i++) begin
      link_next[i] = '0;
      link_prev[i] = '0;
      slot_owner[i] = '0;
      slot_busy[i] = 1'b0;
    end
    for (int i = 0; i < QUEUES; i++) begin
      q_head[i] = NIL;
      q_tail[i] = NIL;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(800);
    wait_drained();
    test_backpressure();
    test_random_traffic(700);
    wait_drained();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
